### sv/fpba_pkg.sv
// shared types, codes and defaults for the fit policy block allocator
`default_nettype none

package fpba_pkg;

  localparam int MAX_BLOCKS_DEF = 32;
  localparam int SIZE_BITS_DEF  = 16;

  localparam int TOTAL_BITS = 21;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

  localparam int CFG_DATA_BITS  = 6;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_POLICY        = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BLOCKS_IN_USE = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ONE_PER_BLOCK = 2'd2;

  localparam logic [1:0] POL_BEST  = 2'd0;
  localparam logic [1:0] POL_FIRST = 2'd1;
  localparam logic [1:0] POL_NEXT  = 2'd2;
  localparam logic [1:0] POL_WORST = 2'd3;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  localparam logic [1:0] POLICY_RST        = POL_BEST;
  localparam logic [5:0] BLOCKS_IN_USE_RST = 6'd32;
  localparam logic       ONE_PER_BLOCK_RST = 1'b1;

  typedef struct packed {
    logic        op;
    logic [4:0]  block_index;
    logic [15:0] amount;
  } request_t;

  typedef struct packed {
    logic                  granted;
    logic [4:0]            chosen_block;
    logic [TOTAL_BITS-1:0] total_used;
  } result_t;

endpackage

`default_nettype wire

### sv/fpba_pick.sv
// running pick of the fit search, one table entry per cycle
`default_nettype none

module fpba_pick #(
  parameter int MAX_BLOCKS = fpba_pkg::MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          clear,
  input  wire logic                          valid,
  input  wire logic [$clog2(MAX_BLOCKS)-1:0] tag,
  input  wire logic                          used,
  input  wire logic [SIZE_BITS-1:0]          size,
  input  wire logic [SIZE_BITS-1:0]          req,
  input  wire logic [1:0]                    policy,
  output logic                               pick_valid,
  output logic [$clog2(MAX_BLOCKS)-1:0]      pick_idx,
  output logic [SIZE_BITS-1:0]               pick_size
);

  logic fit;
  logic better;
  logic take;

  always_comb begin
    fit = !used && (size >= req);
    case (policy)
      fpba_pkg::POL_BEST:  better = size < pick_size;
      fpba_pkg::POL_WORST: better = size > pick_size;
      default:             better = 1'b0;
    endcase
    take = valid && fit && (!pick_valid || better);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pick_valid <= 1'b0;
    end else if (clear) begin
      pick_valid <= 1'b0;
    end else if (take) begin
      pick_valid <= 1'b1;
      pick_idx   <= tag;
      pick_size  <= size;
    end
  end

endmodule

`default_nettype wire

### sv/fit_policy_block_allocator.sv
// top level of the fit policy block allocator: block table, search sequencer, totals
`default_nettype none

// A load request is written into the block table at once and its result pulses done in
// the next cycle. An allocate request scans m blocks, where m is blocks_in_use saturated
// to MAX_BLOCKS: the table sits in one synchronous memory with a single read port, so the
// search reads one block per cycle, then settles its last compare and writes back the
// chosen block and the total. With m equal to zero the request misses at once, with done
// pulsing in the next cycle. After reset a clearing pass over all MAX_BLOCKS entries
// resets the used marks, with busy high meanwhile. Each result is shown on result for
// exactly the one cycle that done is high and the receiver cannot stall it.
// Configuration writes belong to idle periods.

module fit_policy_block_allocator #(
  parameter int MAX_BLOCKS = fpba_pkg::MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire fpba_pkg::request_t                  request,
  output logic                                     done,
  output fpba_pkg::result_t                        result,
  input  wire logic                                cfg_we,
  input  wire logic [fpba_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [fpba_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int IW   = $clog2(MAX_BLOCKS);
  localparam int CW   = $clog2(MAX_BLOCKS + 1);
  localparam int SW   = SIZE_BITS;
  localparam int TB   = fpba_pkg::TOTAL_BITS;
  localparam int SUMW = ((SW > TB) ? SW : TB) + 1;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_SCAN, ST_UPDATE} state_t;

  state_t          state;
  logic [IW-1:0]   clr_addr;
  logic [IW-1:0]   addr;
  logic [CW-1:0]   cnt;
  logic            rd_pend;
  logic [IW-1:0]   rd_tag;
  logic [SW:0]     rd_word;
  logic [SW-1:0]   req_amt;
  logic [IW-1:0]   last_chosen;
  logic [TB-1:0]   total;

  logic [1:0]      policy;
  logic [5:0]      blocks_in_use;
  logic            one_per_block;

  logic [SW:0]     mem [MAX_BLOCKS];

  logic            accept;
  logic            load_ok;
  logic [SW-1:0]   amt_in;
  logic [CW-1:0]   m;
  logic [IW-1:0]   scan_start;
  logic [IW-1:0]   addr_next;
  logic            rd_en;
  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  logic [SW:0]     mem_wdata;
  logic [SUMW-1:0] sum;
  logic [TB-1:0]   total_next;

  logic            pick_valid;
  logic [IW-1:0]   pick_idx;
  logic [SW-1:0]   pick_size;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    amt_in  = SW'(request.amount);
    load_ok = (32'(request.block_index) < MAX_BLOCKS);

    if (32'(blocks_in_use) > MAX_BLOCKS) begin
      m = CW'(MAX_BLOCKS);
    end else begin
      m = CW'(blocks_in_use);
    end

    if ((policy == fpba_pkg::POL_NEXT) && (CW'(last_chosen) < m)) begin
      scan_start = last_chosen;
    end else begin
      scan_start = '0;
    end

    if (CW'(addr) == (m - CW'(1))) begin
      addr_next = '0;
    end else begin
      addr_next = addr + IW'(1);
    end

    rd_en = (state == ST_SCAN) && (cnt != m);

    sum = SUMW'(total) + SUMW'(req_amt);
    if (sum > SUMW'(fpba_pkg::TOTAL_MAX)) begin
      total_next = fpba_pkg::TOTAL_MAX;
    end else begin
      total_next = TB'(sum);
    end

    mem_we    = 1'b0;
    mem_waddr = pick_idx;
    mem_wdata = {one_per_block, pick_size - req_amt};
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        mem_we    = accept && (request.op == fpba_pkg::OP_LOAD) && load_ok;
        mem_waddr = IW'(request.block_index);
        mem_wdata = {1'b0, amt_in};
      end
      ST_UPDATE: begin
        mem_we = pick_valid;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word <= mem[addr];
    end
  end

  fpba_pick #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_pick (
    .clk        (clk),
    .rst        (rst),
    .clear      (accept && (request.op == fpba_pkg::OP_ALLOC)),
    .valid      (rd_pend),
    .tag        (rd_tag),
    .used       (rd_word[SW]),
    .size       (rd_word[SW-1:0]),
    .req        (req_amt),
    .policy     (policy),
    .pick_valid (pick_valid),
    .pick_idx   (pick_idx),
    .pick_size  (pick_size)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      cnt           <= '0;
      rd_pend       <= 1'b0;
      done          <= 1'b0;
      last_chosen   <= '0;
      total         <= '0;
      policy        <= fpba_pkg::POLICY_RST;
      blocks_in_use <= fpba_pkg::BLOCKS_IN_USE_RST;
      one_per_block <= fpba_pkg::ONE_PER_BLOCK_RST;
    end else begin
      done <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          fpba_pkg::CFG_POLICY:        policy        <= cfg_data[1:0];
          fpba_pkg::CFG_BLOCKS_IN_USE: blocks_in_use <= cfg_data;
          fpba_pkg::CFG_ONE_PER_BLOCK: one_per_block <= cfg_data[0];
          default: ;
        endcase
      end

      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + IW'(1);
          if (32'(clr_addr) == MAX_BLOCKS - 1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            req_amt <= amt_in;
            if ((request.op == fpba_pkg::OP_ALLOC) && (m != '0)) begin
              state <= ST_SCAN;
              addr  <= scan_start;
              cnt   <= '0;
            end else begin
              done                <= 1'b1;
              result.granted      <= 1'b0;
              result.chosen_block <= '0;
              result.total_used   <= total;
            end
          end
        end
        ST_SCAN: begin
          if (cnt != m) begin
            rd_pend <= 1'b1;
            rd_tag  <= addr;
            addr    <= addr_next;
            cnt     <= cnt + CW'(1);
          end else begin
            rd_pend <= 1'b0;
            state   <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          state          <= ST_IDLE;
          done           <= 1'b1;
          result.granted <= pick_valid;
          if (pick_valid) begin
            last_chosen         <= pick_idx;
            total               <= total_next;
            result.chosen_block <= 5'(pick_idx);
            result.total_used   <= total_next;
          end else begin
            result.chosen_block <= '0;
            result.total_used   <= total;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/fpba_checker.sv
// port level checks of the fit policy block allocator and their bind
`default_nettype none

module fpba_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               start,
  input wire logic               busy,
  input wire fpba_pkg::request_t request,
  input wire logic               done,
  input wire fpba_pkg::result_t  result
);

  // a result always comes out with the block ready for the next request
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  a_miss_block: assert property (@(posedge clk) disable iff (rst)
    (done && !result.granted) |-> (result.chosen_block == 5'd0))
    else $error("chosen_block not zero on a miss or load");

  a_load_one: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (request.op == fpba_pkg::OP_LOAD)) |=> (done && !result.granted))
    else $error("load request did not finish in one cycle");

  a_alloc_moves: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted request neither working nor finished");

  a_total_grows: assert property (@(posedge clk) disable iff (rst)
    (done && $past(done)) |-> (result.total_used >= $past(result.total_used)))
    else $error("total_used went down");

endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .request (request),
  .done    (done),
  .result  (result)
);

`default_nettype wire
